[rtl/dfs_maze_carver_assert.svh]
// Assertion macros used by the checker file.
`ifndef DFS_MAZE_CARVER_ASSERT_SVH
`define DFS_MAZE_CARVER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define DMC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmc assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define DMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmc assertion failed");

`endif

[rtl/dmc_pkg.sv]
package dmc_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 64;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int DEPTH_W  = $clog2(CELLS + 1);

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [1:0] {
    RSEL_NB,
    RSEL_CELL,
    RSEL_USER
  } rsel_e;

  typedef struct packed {
    logic  init;
    logic  clr_step;
    logic  draw_load;
    logic  advance;
    logic  set_done;
    logic  pop_issue;
    logic  pop_load;
    logic  carve_nb;
    logic  carve_cell;
    rsel_e rsel;
    logic  emit;
    logic  emit_rej;
    logic  emit_walls;
  } dmc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic wait_ph;
    logic rej;
    logic tries_end;
    logic depth_zero;
    logic nb_ok;
    logic rd_zero;
  } dmc_sts_t;

endpackage

[rtl/dfs_maze_carver.sv]
// Accept to registered result word: a read passes S_RD; a rejected or ignored draw and a spare
// action emit from idle. Accepted draw: each try starts in S_TRY and advances there when out of
//   bounds; a visited neighbour returns via S_CHECK, a pop via S_POP; a carve ends in S_CARVE.
// Throughput: one word at a time; the next start is taken as the result word goes out.
// Reset: clear of all 2048 cells of the opening store with busy high, no result word.
// The receiver cannot stall; each result word is strobed for one cycle.
module dfs_maze_carver import dmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [1:0]  rand_value_i,
  input  logic [4:0]  row_i,
  input  logic [5:0]  col_i,
  output logic        result_strobe_o,
  output logic        need_random_o,
  output logic        done_res_o,
  output logic        rejected_o,
  output logic [3:0]  cell_walls_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dmc_cmd_t   cmd;
  dmc_sts_t   sts;
  logic [5:0] grid_rows;
  logic [6:0] grid_cols;

  dmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .grid_rows_o (grid_rows),
    .grid_cols_o (grid_cols)
  );

  dmc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .busy     (busy),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  dmc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .grid_rows_i     (grid_rows),
    .grid_cols_i     (grid_cols),
    .rand_value_i    (rand_value_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .result_strobe_o (result_strobe_o),
    .need_random_o   (need_random_o),
    .done_res_o      (done_res_o),
    .rejected_o      (rejected_o),
    .cell_walls_o    (cell_walls_o)
  );

endmodule

[rtl/dmc_cfg.sv]
module dmc_cfg import dmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [5:0]  grid_rows_o,
  output logic [6:0]  grid_cols_o
);

  logic [5:0] grid_rows_q, grid_rows_d;
  logic [6:0] grid_cols_q, grid_cols_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    grid_rows_d = grid_rows_q;
    grid_cols_d = grid_cols_q;
    if (wr_en) begin
      if (paddr[2]) begin
        grid_cols_d = pwdata[6:0];
      end else begin
        grid_rows_d = pwdata[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= 6'd10;
      grid_cols_q <= 7'd20;
    end else begin
      grid_rows_q <= grid_rows_d;
      grid_cols_q <= grid_cols_d;
    end
  end

  assign prdata      = paddr[2] ? 32'(grid_cols_q) : 32'(grid_rows_q);
  assign grid_rows_o = grid_rows_q;
  assign grid_cols_o = grid_cols_q;

endmodule

[rtl/dmc_dp.sv]
module dmc_dp import dmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dmc_cmd_t   cmd_i,
  output dmc_sts_t   sts_o,
  input  logic [5:0] grid_rows_i,
  input  logic [6:0] grid_cols_i,
  input  logic [1:0] rand_value_i,
  input  logic [4:0] row_i,
  input  logic [5:0] col_i,
  output logic       result_strobe_o,
  output logic       need_random_o,
  output logic       done_res_o,
  output logic       rejected_o,
  output logic [3:0] cell_walls_o
);

  localparam int ROWSZ_W = $clog2(MAX_ROWS + 1);
  localparam int COLSZ_W = $clog2(MAX_COLS + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [1:0]       dir;
    logic [2:0]       tries;
  } frame_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

  logic [1:0]         phase_q, phase_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [1:0]         dir_q, dir_d;
  logic [2:0]         tries_q, tries_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [3:0]         link_q, link_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               strobe_q;
  logic               need_q, done_q, rej_q;
  logic [3:0]         walls_q;
  logic               rd_ok_q;

  logic [3:0]         store_mem [CELLS];
  logic [3:0]         st_rdata_q;
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr, st_raddr;
  logic [3:0]         st_wdata;

  frame_t             stack_mem [CELLS];
  frame_t             stk_rdata_q;
  frame_t             push_frame;
  logic [DEPTH_W-1:0] depth_m1;

  logic [ROWSZ_W-1:0] rows_eff;
  logic [COLSZ_W-1:0] cols_eff;
  logic [ROW_W-1:0]   nb_row;
  logic [COL_W-1:0]   nb_col;
  logic               nb_inb;
  logic [3:0]         dir_bit, opp_bit, rv_bit;
  logic               user_ok;
  logic [ADDR_W-1:0]  user_addr;

  // effective grid size
  always_comb begin
    if (grid_rows_i == '0) begin
      rows_eff = ROWSZ_W'(1);
    end else if (int'(grid_rows_i) > MAX_ROWS) begin
      rows_eff = ROWSZ_W'(MAX_ROWS);
    end else begin
      rows_eff = ROWSZ_W'(grid_rows_i);
    end
    if (grid_cols_i == '0) begin
      cols_eff = COLSZ_W'(1);
    end else if (int'(grid_cols_i) > MAX_COLS) begin
      cols_eff = COLSZ_W'(MAX_COLS);
    end else begin
      cols_eff = COLSZ_W'(grid_cols_i);
    end
  end

  // neighbour in the current try direction
  always_comb begin
    nb_row = row_q;
    nb_col = col_q;
    nb_inb = 1'b0;
    case (dir_q)
      DIR_UP: begin
        nb_inb = (row_q != '0);
        nb_row = row_q - ROW_W'(1);
      end
      DIR_DOWN: begin
        nb_inb = (ROWSZ_W'(row_q) + ROWSZ_W'(1)) < rows_eff;
        nb_row = row_q + ROW_W'(1);
      end
      DIR_LEFT: begin
        nb_inb = (col_q != '0);
        nb_col = col_q - COL_W'(1);
      end
      default: begin
        nb_inb = (COLSZ_W'(col_q) + COLSZ_W'(1)) < cols_eff;
        nb_col = col_q + COL_W'(1);
      end
    endcase
  end

  assign dir_bit   = 4'b0001 << dir_q;
  assign opp_bit   = 4'b0001 << (dir_q + 2'd2);
  assign rv_bit    = 4'b0001 << rand_value_i;
  assign user_ok   = (int'(row_i) < MAX_ROWS) && (int'(col_i) < MAX_COLS);
  assign user_addr = ADDR_W'(int'(row_i) * MAX_COLS + int'(col_i));
  assign depth_m1  = depth_q - DEPTH_W'(1);

  assign push_frame = '{row: row_q, col: col_q, dir: dir_q, tries: tries_q};

  // opening store ports
  always_comb begin
    st_we    = 1'b0;
    st_waddr = clr_q;
    st_wdata = '0;
    if (cmd_i.clr_step) begin
      st_we = 1'b1;
    end else if (cmd_i.carve_nb) begin
      st_we    = 1'b1;
      st_waddr = cell_addr(nb_row, nb_col);
      st_wdata = opp_bit;
    end else if (cmd_i.carve_cell) begin
      st_we    = 1'b1;
      st_waddr = cell_addr(row_q, col_q);
      st_wdata = st_rdata_q | dir_bit;
    end
    case (cmd_i.rsel)
      RSEL_CELL: st_raddr = cell_addr(row_q, col_q);
      RSEL_USER: st_raddr = user_addr;
      default:   st_raddr = cell_addr(nb_row, nb_col);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    st_rdata_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.carve_cell) begin
      stack_mem[depth_q[ADDR_W-1:0]] <= push_frame;
    end
    stk_rdata_q <= stack_mem[depth_m1[ADDR_W-1:0]];
    rd_ok_q     <= user_ok;
  end

  // walk registers
  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    dir_d   = dir_q;
    tries_d = tries_q;
    depth_d = depth_q;
    link_d  = link_q;
    clr_d   = clr_q;
    if (cmd_i.init) begin
      phase_d = PH_WAIT;
      row_d   = '0;
      col_d   = '0;
      dir_d   = '0;
      tries_d = '0;
      depth_d = '0;
      link_d  = '0;
      clr_d   = '0;
    end
    if (cmd_i.clr_step) begin
      clr_d = clr_q + ADDR_W'(1);
    end
    if (cmd_i.draw_load) begin
      dir_d   = rand_value_i;
      tries_d = '0;
    end
    if (cmd_i.advance) begin
      dir_d   = dir_q + 2'd1;
      tries_d = tries_q + 3'd1;
    end
    if (cmd_i.set_done) begin
      phase_d = PH_DONE;
    end
    if (cmd_i.pop_issue) begin
      depth_d = depth_m1;
    end
    if (cmd_i.pop_load) begin
      row_d   = stk_rdata_q.row;
      col_d   = stk_rdata_q.col;
      dir_d   = stk_rdata_q.dir + 2'd1;
      tries_d = stk_rdata_q.tries + 3'd1;
    end
    if (cmd_i.carve_cell) begin
      depth_d = depth_q + DEPTH_W'(1);
      row_d   = nb_row;
      col_d   = nb_col;
      link_d  = opp_bit;
      phase_d = PH_WAIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      row_q    <= '0;
      col_q    <= '0;
      dir_q    <= '0;
      tries_q  <= '0;
      depth_q  <= '0;
      link_q   <= '0;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      row_q    <= row_d;
      col_q    <= col_d;
      dir_q    <= dir_d;
      tries_q  <= tries_d;
      depth_q  <= depth_d;
      link_q   <= link_d;
      clr_q    <= clr_d;
      strobe_q <= cmd_i.emit;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      need_q  <= (phase_d == PH_WAIT);
      done_q  <= (phase_d == PH_DONE);
      rej_q   <= cmd_i.emit_rej;
      walls_q <= cmd_i.emit_walls ? (st_rdata_q & {4{rd_ok_q}}) : 4'd0;
    end
  end

  assign sts_o.clr_last   = (clr_q == ADDR_W'(CELLS - 1));
  assign sts_o.wait_ph    = (phase_q == PH_WAIT);
  assign sts_o.rej        = (rv_bit == link_q);
  assign sts_o.tries_end  = tries_q[2];
  assign sts_o.depth_zero = (depth_q == '0);
  assign sts_o.nb_ok      = nb_inb && (depth_q != DEPTH_W'(CELLS));
  assign sts_o.rd_zero    = (st_rdata_q == '0);

  assign result_strobe_o = strobe_q;
  assign need_random_o   = need_q;
  assign done_res_o      = done_q;
  assign rejected_o      = rej_q;
  assign cell_walls_o    = walls_q;

endmodule

[rtl/dmc_ctrl.sv]
module dmc_ctrl import dmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] action_i,
  output logic       busy,
  input  dmc_sts_t   sts_i,
  output dmc_cmd_t   cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TRY   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_CARVE = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       clr_emit_q, clr_emit_d;

  always_comb begin
    state_d    = state_q;
    clr_emit_d = clr_emit_q;
    cmd_o      = '0;
    cmd_o.rsel = RSEL_NB;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d    = S_IDLE;
          cmd_o.emit = clr_emit_q;
          clr_emit_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (action_i)
            ACT_CLEAR: begin
              cmd_o.init = 1'b1;
              clr_emit_d = 1'b1;
              state_d    = S_CLEAR;
            end
            ACT_DRAW: begin
              if (sts_i.wait_ph && !sts_i.rej) begin
                cmd_o.draw_load = 1'b1;
                state_d         = S_TRY;
              end else begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_rej = sts_i.wait_ph;
              end
            end
            ACT_READ: begin
              cmd_o.rsel = RSEL_USER;
              state_d    = S_RD;
            end
            default: begin
              cmd_o.emit = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_walls = 1'b1;
        state_d          = S_IDLE;
      end
      S_TRY: begin
        if (sts_i.tries_end) begin
          if (sts_i.depth_zero) begin
            cmd_o.set_done = 1'b1;
            cmd_o.emit     = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd_o.pop_issue = 1'b1;
            state_d         = S_POP;
          end
        end else if (!sts_i.nb_ok) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.rsel = RSEL_NB;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.rd_zero) begin
          cmd_o.advance = 1'b1;
          state_d       = S_TRY;
        end else begin
          cmd_o.carve_nb = 1'b1;
          cmd_o.rsel     = RSEL_CELL;
          state_d        = S_CARVE;
        end
      end
      S_CARVE: begin
        cmd_o.carve_cell = 1'b1;
        cmd_o.emit       = 1'b1;
        state_d          = S_IDLE;
      end
      S_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_TRY;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_emit_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_emit_q <= clr_emit_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

[rtl/dmc_checker.sv]
`include "dfs_maze_carver_assert.svh"

module dmc_checker import dmc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] action_i,
  input logic       result_strobe_o,
  input logic       need_random_o,
  input logic       done_res_o,
  input logic       rejected_o,
  input logic [3:0] cell_walls_o
);

  `DMC_ASSERT_IMPL(a_phase_excl, result_strobe_o, !(need_random_o && done_res_o))
  `DMC_ASSERT_IMPL(a_rej_waits, result_strobe_o && rejected_o, need_random_o)
  `DMC_ASSERT_IMPL(a_rej_no_walls, result_strobe_o && rejected_o, cell_walls_o == 4'd0)
  `DMC_ASSERT_NEXT(a_clear_busy, start && !busy && (action_i == ACT_CLEAR), busy)

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (.*);
